// ===== rtl/kscd_pkg.sv =====
//------------------------------------------------------------------------------
// kscd_pkg
// Shared constants and types of the set-1 scancode event decoder.
//------------------------------------------------------------------------------
package kscd_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int EXT_BASE    = 96;
	localparam int KEY_COUNT   = 192;

	localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_AW   = $clog2(KEY_COUNT);
	localparam int CODE_W   = 8;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	localparam logic KIND_RAW  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] BYTE_EXT   = 8'hE0;
	localparam logic [7:0] BYTE_SKIP1 = 8'hE1;
	localparam logic [7:0] BYTE_SKIP2 = 8'hE2;
	localparam logic [6:0] SC_LIMIT   = 7'h60;

	typedef struct packed {
		logic              note;
		logic              down;
		logic [KEY_AW-1:0] idx;
	} key_req_t;

	typedef struct packed {
		logic              avail;
		logic              down;
		logic [CODE_W-1:0] code;
	} result_t;

endpackage

// ===== rtl/keyboard_scancode_event_decoder_core.sv =====
//------------------------------------------------------------------------------
// keyboard_scancode_event_decoder_core
// Set-1 scancode decoder with pressed-key bitmap and event queue.
//------------------------------------------------------------------------------
// Accepts one transaction per clock while ready is high. A raw byte (tuser = 0)
// updates the prefix state and the pressed-key bitmap and queues a key event on
// a real change; a read (tuser = 1) pops one event and returns exactly one
// result, via the stage-1 and stage-2 registers, through a four-entry output
// buffer. Bitmap and event queue are two-port synchronous memories updated by
// read-modify-write in the first stage, with a one-deep bypass for back-to-back
// hits on one key. Input ready drops only when the output buffer plus reads
// still in flight would reach four entries, so a stalled output costs rate only
// after that. Reset takes effect at once: the bitmap has per-key valid bits, no
// clearing pass. A full event queue drops new events; an empty one answers with
// available = 0 and zero key fields.
//------------------------------------------------------------------------------
module keyboard_scancode_event_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // raw_byte[7:0]
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // key_down, key_code[8:1], zero pad
	output logic        m_axis_tuser   // available
);
	import kscd_pkg::*;

	logic                accept;
	logic                raw_acc;
	logic                rd_acc;
	key_req_t            req;

	logic                key_s1;
	logic                rd_s1;
	logic                down_s1;
	logic [KEY_AW-1:0]   idx_s1;
	logic                fwd_s1;
	logic                fwd_val_s1;
	logic                key_rd_s1;
	logic                key_vld_s1;
	logic                old_s1;
	logic                key_wr;

	logic                key_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] key_vld_q;

	logic [CODE_W:0]     evt_mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q;
	logic [QUEUE_AW-1:0] rp_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                push;
	logic                pop;

	logic                rd_s2;
	logic                avail_s2;
	logic [CODE_W:0]     evt_s2;
	result_t             res_s2;
	result_t             head;
	logic [OUT_CW-1:0]   fifo_cnt;
	logic [OUT_CW:0]     pend;

	assign pend = {1'b0, fifo_cnt} + (OUT_CW + 1)'(rd_s1) + (OUT_CW + 1)'(rd_s2);
	assign s_axis_tready = pend < (OUT_CW + 1)'(OUT_DEPTH);
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign raw_acc = accept && (s_axis_tuser == KIND_RAW);
	assign rd_acc  = accept && (s_axis_tuser == KIND_READ);

	kscd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw_en   (raw_acc),
		.raw_byte (s_axis_tdata),
		.req      (req)
	);

	// stage 1: bitmap read-modify-write, queue push and pop
	assign old_s1 = fwd_s1 ? fwd_val_s1 : (key_vld_s1 & key_rd_s1);
	assign key_wr = key_s1 && (old_s1 != down_s1);
	assign push   = key_wr && (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop    = rd_s1 && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_mem[idx_s1] <= down_s1;
		end
		key_rd_s1  <= key_mem[req.idx];
		key_vld_s1 <= key_vld_q[req.idx];
		idx_s1     <= req.idx;
		down_s1    <= req.down;
		fwd_val_s1 <= down_s1;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			evt_mem[wp_q] <= {down_s1, CODE_W'(idx_s1)};
		end
		if (pop) begin
			evt_s2 <= evt_mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_s1    <= 1'b0;
			rd_s1     <= 1'b0;
			fwd_s1    <= 1'b0;
			key_vld_q <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			rd_s2     <= 1'b0;
			avail_s2  <= 1'b0;
		end else begin
			key_s1   <= raw_acc && req.note;
			rd_s1    <= rd_acc;
			fwd_s1   <= key_wr && (idx_s1 == req.idx);
			rd_s2    <= rd_s1;
			avail_s2 <= pop;
			if (key_wr) begin
				key_vld_q[idx_s1] <= 1'b1;
			end
			if (push) begin
				wp_q <= (wp_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// stage 2: result into output buffer
	assign res_s2.avail = avail_s2;
	assign res_s2.down  = avail_s2 & evt_s2[CODE_W];
	assign res_s2.code  = avail_s2 ? evt_s2[CODE_W-1:0] : '0;

	kscd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rd_s2),
		.wr_data   (res_s2),
		.rd_en     (m_axis_tready),
		.rd_data   (head),
		.not_empty (m_axis_tvalid),
		.count     (fifo_cnt)
	);

	assign m_axis_tuser = head.avail;
	assign m_axis_tdata = {7'b0, head.code, head.down};

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s2 |-> (fifo_cnt != OUT_CW'(OUT_DEPTH)) || m_axis_tready)
		else $error("output buffer overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("event count out of range");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cnt_q == $past(cnt_q) - QUEUE_CW'(1))
		else $error("event count not decremented on pop");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
		else $error("empty read carries key data");

endmodule

// ===== rtl/kscd_decode.sv =====
//------------------------------------------------------------------------------
// kscd_decode
// Prefix tracking and key index decode of raw set-1 bytes.
//------------------------------------------------------------------------------
module kscd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_en,
	input  logic [7:0]        raw_byte,
	output kscd_pkg::key_req_t req
);
	import kscd_pkg::*;

	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_EXT  = 2'd1;
	localparam logic [1:0] PFX_SKIP = 2'd2;

	logic [1:0] pfx_q;
	logic [1:0] pfx_nxt;
	logic [6:0] sc;
	logic       sc_ok;
	logic       note;
	logic       ext;
	logic [8:0] sum;

	assign sc    = raw_byte[6:0];
	assign sc_ok = sc < SC_LIMIT;

	always_comb begin
		pfx_nxt = PFX_NONE;
		note    = 1'b0;
		ext     = 1'b0;
		unique case (pfx_q)
			PFX_EXT: begin
				note = sc_ok;
				ext  = 1'b1;
			end
			PFX_SKIP: begin
				pfx_nxt = PFX_NONE;
			end
			PFX_NONE: begin
				if (raw_byte == BYTE_EXT) begin
					pfx_nxt = PFX_EXT;
				end else if (raw_byte == BYTE_SKIP1 || raw_byte == BYTE_SKIP2) begin
					pfx_nxt = PFX_SKIP;
				end else begin
					note = sc_ok;
				end
			end
			default: begin
				pfx_nxt = PFX_NONE;
			end
		endcase
	end

	assign sum = ext ? ({2'b00, sc} + 9'(EXT_BASE)) : {2'b00, sc};

	assign req.note = note && (sum < 9'(KEY_COUNT));
	assign req.down = ~raw_byte[7];
	assign req.idx  = sum[KEY_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q <= PFX_NONE;
		end else if (raw_en) begin
			pfx_q <= pfx_nxt;
		end
	end

endmodule

// ===== rtl/kscd_out_fifo.sv =====
//------------------------------------------------------------------------------
// kscd_out_fifo
// Small result buffer in front of the output stream.
//------------------------------------------------------------------------------
module kscd_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  kscd_pkg::result_t         wr_data,
	input  logic                      rd_en,
	output kscd_pkg::result_t         rd_data,
	output logic                      not_empty,
	output logic [kscd_pkg::OUT_CW-1:0] count
);
	import kscd_pkg::*;

	result_t           buf_q [OUT_DEPTH];
	logic [OUT_AW-1:0] head_q;
	logic [OUT_AW-1:0] tail_q;
	logic [OUT_CW-1:0] cnt_q;
	logic              pop;

	assign not_empty = cnt_q != '0;
	assign pop       = rd_en && not_empty;
	assign rd_data   = buf_q[head_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				tail_q <= (tail_q == OUT_AW'(OUT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == OUT_AW'(OUT_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (wr_en && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sim/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// Testbench of the set-1 scancode event decoder core.
//------------------------------------------------------------------------------
// Drives raw keyboard bytes and read requests into the slave stream and checks
// every read answer on the master stream. The expected answers come from a
// behavioral copy of the prefix state, the pressed-key bitmap and the event
// queue. Directed tests cover prefixes, dropped codes, repeats and the empty
// queue. A fill test overflows the queue and wraps its pointers. A random test
// mixes well-formed key sequences with noise. The sender idles in bursts and
// the receiver stalls in patterns of its own.
//------------------------------------------------------------------------------
module tb_top;
	import kscd_pkg::*;

	typedef enum logic [1:0] {PFX_NONE, PFX_EXT, PFX_SKIP} prefix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // raw_byte[7:0]
	logic        s_axis_tuser = 1'b0;    // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // key_down, key_code[8:1], zero pad
	logic        m_axis_tuser;           // available

	prefix_t      prefix_state;
	logic [255:0] key_is_down;
	logic [8:0]   queued_events[$];
	result_t      expected_reads[$];

	int error_count = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	keyboard_scancode_event_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 40)
			$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic note_key_change(input int idx, input logic down);
		if (idx >= KEY_COUNT)
			return;
		if (key_is_down[idx] == down)
			return;
		key_is_down[idx] = down;
		if (queued_events.size() >= QUEUE_DEPTH)
			return;
		queued_events.push_back({down, idx[7:0]});
	endtask

	task automatic predict_keyboard_item(input logic kind, input logic [7:0] raw);
		result_t    ans;
		logic [8:0] ev;
		logic       down;
		logic [6:0] sc;
		if (kind == KIND_READ) begin
			ans = '0;
			if (queued_events.size() != 0) begin
				ev = queued_events.pop_front();
				ans.avail = 1'b1;
				ans.down = ev[8];
				ans.code = ev[7:0];
			end
			expected_reads.push_back(ans);
			return;
		end
		down = ~raw[7];
		sc = raw[6:0];
		case (prefix_state)
			PFX_EXT: begin
				if (sc < SC_LIMIT)
					note_key_change(int'(sc) + EXT_BASE, down);
				prefix_state = PFX_NONE;
			end
			PFX_SKIP: prefix_state = PFX_NONE;
			default: begin
				if (raw == BYTE_EXT)
					prefix_state = PFX_EXT;
				else if (raw == BYTE_SKIP1 || raw == BYTE_SKIP2)
					prefix_state = PFX_SKIP;
				else if (sc < SC_LIMIT)
					note_key_change(int'(sc), down);
			end
		endcase
	endtask

	task automatic send_item(input logic kind, input logic [7:0] raw);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = raw;
		do @(posedge clk); while (!s_axis_tready);
		predict_keyboard_item(kind, raw);
	endtask

	task automatic wait_all_answered();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (expected_reads.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 7) != 0);
			default: m_axis_tready <= (rx_left % 12 == 0);
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reads.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = expected_reads.pop_front();
				if (m_axis_tuser !== want.avail)
					report_mismatch($sformatf("available got %b want %b",
						m_axis_tuser, want.avail));
				if (m_axis_tdata[0] !== want.down)
					report_mismatch($sformatf("key_down got %b want %b",
						m_axis_tdata[0], want.down));
				if (m_axis_tdata[8:1] !== want.code)
					report_mismatch($sformatf("key_code got %h want %h",
						m_axis_tdata[8:1], want.code));
				if (m_axis_tdata[15:9] !== 7'd0)
					report_mismatch($sformatf("pad bits got %h", m_axis_tdata[15:9]));
			end
		end
	end

	task automatic test_directed();
		send_item(KIND_READ, 8'hFF);     // empty queue
		send_item(KIND_RAW, 8'h00);
		send_item(KIND_RAW, 8'h00);      // repeat suppressed
		send_item(KIND_RAW, 8'h80);
		send_item(KIND_RAW, 8'h5F);
		send_item(KIND_RAW, 8'h60);      // dropped code
		send_item(KIND_RAW, 8'h7F);
		send_item(KIND_RAW, 8'hFF);
		send_item(KIND_RAW, BYTE_EXT);
		send_item(KIND_READ, BYTE_EXT);  // read leaves prefix alone
		send_item(KIND_RAW, 8'h1C);
		send_item(KIND_RAW, BYTE_EXT);
		send_item(KIND_RAW, 8'h5F);      // highest key index
		send_item(KIND_RAW, BYTE_EXT);
		send_item(KIND_RAW, 8'hE0);      // prefix while extended pending
		send_item(KIND_RAW, 8'h9C);      // plain break, key not down
		send_item(KIND_RAW, BYTE_SKIP1);
		send_item(KIND_RAW, 8'h1D);
		send_item(KIND_RAW, BYTE_SKIP2);
		send_item(KIND_RAW, 8'h45);
		send_item(KIND_RAW, BYTE_EXT);
		send_item(KIND_RAW, 8'hDF);
		repeat (6) send_item(KIND_READ, 8'h00);
		wait_all_answered();
	endtask

	task automatic test_queue_overflow();
		for (int i = 0; i < QUEUE_DEPTH + 40; i++)
			send_item(KIND_RAW, (i % 2 == 0) ? 8'h10 : 8'h90);
		send_item(KIND_RAW, 8'h11);
		for (int i = 0; i < QUEUE_DEPTH + 3; i++)
			send_item(KIND_READ, 8'($urandom_range(0, 255)));
		send_item(KIND_RAW, 8'h91);
		send_item(KIND_READ, 8'hAA);
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int r;
		logic [6:0] sc;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			sc = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7))
			                                 : 7'($urandom_range(0, 'h5F));
			if (r < 35) begin
				send_item(KIND_READ, 8'($urandom_range(0, 255)));
				sent++;
			end else if (r < 75) begin
				send_item(KIND_RAW, {1'($urandom_range(0, 1)), sc});
				sent++;
			end else if (r < 86) begin
				send_item(KIND_RAW, BYTE_EXT);
				if ($urandom_range(0, 4) == 0)
					send_item(KIND_RAW, 8'($urandom_range(0, 255)));
				else
					send_item(KIND_RAW, {1'($urandom_range(0, 1)), sc});
				sent += 2;
			end else if (r < 92) begin
				send_item(KIND_RAW, ($urandom_range(0, 1) == 0) ? BYTE_SKIP1 : BYTE_SKIP2);
				send_item(KIND_RAW, 8'($urandom_range(0, 255)));
				sent += 2;
			end else begin
				send_item(KIND_RAW, 8'($urandom_range(0, 255)));
				sent++;
			end
			if (sent % 400 == 0 && sent != 0)
				wait_all_answered();
		end
	endtask

	task automatic test_drain_pause();
		repeat (10) send_item(KIND_RAW, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 'h5F))});
		repeat (5) send_item(KIND_READ, 8'h00);
		wait_all_answered();
		repeat ($urandom_range(1, 10)) @(negedge clk);
		repeat (5) send_item(KIND_READ, 8'h00);
	endtask

	initial begin
		int spin;
		prefix_state = PFX_NONE;
		key_is_down = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_queue_overflow();
		test_drain_pause();
		test_random_traffic(550);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		spin = 0;
		while (expected_reads.size() != 0 && spin < 100_000) begin
			@(posedge clk);
			spin++;
		end
		repeat (20) @(posedge clk);
		if (expected_reads.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_reads.size()));
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
